@@ sv/sha256_stream_hasher_top_macros.svh @@
// Assertion macros for the SHA-256 stream hasher controller.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ sv/shs_pkg.sv @@
// Package with SHA-256 constants, functions and the controller-datapath command and status types.
package shs_pkg;

	// Datapath commands issued by the controller.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_PUSH,
		CMD_ROUND,
		CMD_FOLD,
		CMD_RESTART,
		CMD_SHIFT_OUT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] push_byte;
		logic       count_msg;
		logic [5:0] round_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0]  fill;
		logic [63:0] msg_bytes;
	} dp_status_t;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
			6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
			6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ sv/shs_datapath.sv @@
// SHA-256 datapath: byte buffer as a 16-word schedule window, working and chaining words.
module shs_datapath
	import shs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic [31:0] head_word
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  fill_q;
	logic [63:0] msg_q;

	logic [31:0] s0, s1, w_new, w_cur, t1, t2, e, a;

	// Message schedule word and round terms.
	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = w_q[0];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(cmd.round_idx) + w_cur;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Control state of the datapath: fill count and message length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			msg_q  <= '0;
		end else begin
			case (cmd.op)
				CMD_PUSH: begin
					fill_q <= fill_q + 6'd1;
					if (cmd.count_msg) msg_q <= msg_q + 64'd1;
				end
				CMD_RESTART: begin
					fill_q <= '0;
					msg_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// Chaining words, reset to the initial hash values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else begin
			case (cmd.op)
				CMD_FOLD: for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				CMD_RESTART: for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
				CMD_SHIFT_OUT: begin
					for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
					h_q[7] <= h_q[0];
				end
				default: ;
			endcase
		end
	end

	// Schedule window and working variables.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_PUSH: begin
				// Bytes shift into the window; after 64 pushes w_q[0] holds word 0.
				for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
				w_q[15] <= {w_q[15][23:0], cmd.push_byte};
				if (fill_q == 6'd63) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			CMD_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	assign status.fill      = fill_q;
	assign status.msg_bytes = msg_q;
	assign head_word        = h_q[0];

endmodule

@@ sv/shs_controller.sv @@
// SHA-256 controller: sequences byte loads, padding, rounds and digest output.
module shs_controller
	import shs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	input  logic        in_valid,
	output logic        in_ready,
	input  dp_status_t  status,
	output dp_cmd_t     cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  word_index,
	output logic        last_word
);
	`include "sha256_stream_hasher_top_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE, S_BYTE, S_PAD, S_ROUND, S_FOLD, S_OUT, S_DONE
	} state_t;

	state_t      state_q;
	logic [7:0]  byte_q;
	logic        last_q, padding_q, tail_q;
	logic [5:0]  round_q;
	logic [2:0]  widx_q;
	logic [63:0] bitlen_q;
	logic [2:0]  len_idx;
	logic [7:0]  pad_byte;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign word_index = widx_q;
	assign last_word  = (widx_q == 3'd7);

	// Pad byte: 0x80 first, zeros, then big-endian bit length in the block that carries it.
	always_comb begin
		len_idx = status.fill[2:0];
		if (!padding_q) pad_byte = PAD_BYTE;
		else if (tail_q && status.fill >= LENGTH_POS) pad_byte = bitlen_q[8*(7-len_idx) +: 8];
		else pad_byte = 8'h00;
	end

	// Command to the datapath.
	always_comb begin
		cmd = '{op: CMD_NONE, push_byte: 8'h00, count_msg: 1'b0, round_idx: round_q};
		case (state_q)
			S_BYTE: begin
				cmd.op = CMD_PUSH; cmd.push_byte = byte_q; cmd.count_msg = 1'b1;
			end
			S_PAD: begin
				cmd.op = CMD_PUSH; cmd.push_byte = pad_byte;
			end
			S_ROUND: cmd.op = CMD_ROUND;
			S_FOLD: cmd.op = CMD_FOLD;
			S_OUT: if (out_ready) cmd.op = CMD_SHIFT_OUT;
			S_DONE: cmd.op = CMD_RESTART;
			default: ;
		endcase
	end

	// State machine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			last_q    <= 1'b0;
			padding_q <= 1'b0;
			tail_q    <= 1'b0;
			round_q   <= '0;
			widx_q    <= '0;
			byte_q    <= '0;
			bitlen_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					byte_q <= data_byte; last_q <= is_last;
					padding_q <= 1'b0;
					tail_q    <= 1'b0;
					if (has_byte) state_q <= S_BYTE;
					else if (is_last) begin
						bitlen_q <= {status.msg_bytes[60:0], 3'b000};
						state_q  <= S_PAD;
					end
				end
				S_BYTE: begin
					if (status.fill == 6'd63) begin
						round_q <= '0; state_q <= S_ROUND;
					end else if (last_q) begin
						state_q  <= S_PAD;
					end else state_q <= S_IDLE;
					if (last_q) bitlen_q <= {status.msg_bytes[60:0] + 61'd1, 3'b000};
				end
				S_PAD: begin
					padding_q <= 1'b1;
					// The length fits behind the 0x80 byte only if that byte lands before 56.
					if (!padding_q) tail_q <= (status.fill < LENGTH_POS);
					if (status.fill == 6'd63) begin
						round_q <= '0; state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= S_FOLD;
				end
				S_FOLD: begin
					// Ends a data block, an overflow padding block or the final block.
					if (last_q && tail_q) begin
						widx_q <= '0; state_q <= S_OUT;
					end else if (last_q) begin
						if (padding_q) tail_q <= 1'b1;
						state_q <= S_PAD;
					end else state_q <= S_IDLE;
				end
				S_OUT: if (out_ready) begin
					widx_q <= widx_q + 3'd1;
					if (widx_q == 3'd7) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SHS_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ready, "input taken while busy")
	`SHS_ASSERT_NEXT(a_round_to_fold, clk, arst_n, state_q == S_ROUND && round_q == 6'd63, state_q == S_FOLD, "round count overrun")
	`SHS_ASSERT_NEXT(a_out_done, clk, arst_n, state_q == S_OUT && out_ready && widx_q == 3'd7, state_q == S_DONE, "digest length wrong")

endmodule

@@ sv/sha256_stream_hasher_top.sv @@
// Top level of the SHA-256 stream hasher.
// A byte request is taken in the idle state and pushed in the byte state; a block boundary adds the
// rounds and a fold. A last request adds padding, one pad byte per push, each padded block's rounds
// and fold, then 8 words. Input is taken only while idle: a single round unit, no block double buffer.
// Reset (arst_n low) loads the initial hash values and clears fill count and length.
module sha256_stream_hasher_top
	import shs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	dp_cmd_t    cmd;
	dp_status_t status;

	shs_controller u_ctrl (
		.clk, .arst_n, .data_byte, .has_byte, .is_last, .in_valid, .in_ready,
		.status, .cmd, .out_valid, .out_ready, .word_index, .last_word
	);

	shs_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .head_word(digest_word)
	);

endmodule

@@ verif/sha256_stream_hasher_checker.sv @@
// Checker that predicts SHA-256 digests from the input requests and compares the output words, indices and last flags.
`timescale 1ns / 1ps
module sha256_stream_hasher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_words
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	localparam logic [31:0] H_INIT [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0]   hash_state [8];
	logic [7:0]    block_bytes [64];
	logic [5:0]    block_fill;
	logic [63:0]   byte_total;
	digest_entry_t digest_queue [$];

	assign pending_words = digest_queue.size();

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of the buffered block into the hash state.
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		if (block_fill == 0)
			compress();
	endtask

	// Update the hash for one accepted request and queue the digest on a last one.
	task automatic absorb_request(input logic [7:0] b, input logic hb, input logic lst);
		logic [63:0] bit_len;
		if (hb) begin
			append_byte(b);
			byte_total++;
		end
		if (lst) begin
			bit_len = byte_total << 3;
			append_byte(8'h80);
			while (block_fill != 6'd56)
				append_byte(8'h00);
			for (int i = 7; i >= 0; i--)
				append_byte(bit_len[8*i +: 8]);
			for (int i = 0; i < 8; i++)
				digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
			hash_state = H_INIT;
			block_fill = '0;
			byte_total = '0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t: digest mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		hash_state = H_INIT;
		block_fill = '0;
		byte_total = '0;
	end

	// Watch both channels at each rising edge.
	always @(posedge clk) begin
		digest_entry_t exp_word;
		if (arst_n) begin
			if (in_valid && in_ready)
				absorb_request(data_byte, has_byte, is_last);
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", digest_word));
				end else begin
					exp_word = digest_queue.pop_front();
					if (digest_word !== exp_word.word)
						report_mismatch($sformatf("word %h, expected %h", digest_word, exp_word.word));
					if (word_index !== exp_word.index)
						report_mismatch($sformatf("index %0d, expected %0d", word_index,
							exp_word.index));
					if (last_word !== exp_word.last)
						report_mismatch($sformatf("last flag %b, expected %b", last_word,
							exp_word.last));
				end
			end
		end
	end

endmodule

@@ verif/sha256_stream_hasher_top_tb.sv @@
// Testbench top for the SHA-256 stream hasher: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module sha256_stream_hasher_top_tb;

	localparam int RANDOM_REQUESTS = 450;
	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          pending_words;
	int          sent_count;
	bit          quiet_phase;
	bit          long_hold;

	sha256_stream_hasher_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

	sha256_stream_hasher_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Present one request and hold it until accepted, with an optional idle burst first.
	// Valid stays high after acceptance; an idle burst before the next request or a pause drops it.
	task automatic send_request(input logic [7:0] b, input logic hb, input logic lst);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		is_last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	// A message of len random bytes, then a last request that carries one more byte if last_has_byte is set.
	task automatic send_message(input int len, input bit last_has_byte);
		for (int i = 0; i < len; i++)
			send_request(8'($urandom), 1'b1, 1'b0);
		send_request(8'($urandom), last_has_byte, 1'b1);
	endtask

	// Receiver: random stall bursts, one long hold-off, none in the final phase.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				long_hold = 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted request or output word.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int len;
		in_valid = 1'b0;
		data_byte = '0;
		has_byte = 1'b0;
		is_last = 1'b0;
		quiet_phase = 1'b0;
		long_hold = 1'b0;
		sent_count = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, no-op request, byte extremes, the message abc, padding boundaries.
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_message(55, 1'b0);
		send_message(55, 1'b1);
		send_message(63, 1'b1);

		// The sender pauses until every digest word has come back.
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);

		// Long receiver hold-off while messages keep coming.
		long_hold = 1'b1;
		send_message(3, 1'b1);
		send_message(2, 1'b0);
		send_message(1, 1'b1);

		// Random messages: mostly short, a few spanning several blocks, with noise requests.
		while (sent_count < RANDOM_REQUESTS) begin
			if (sent_count > RANDOM_REQUESTS - 80)
				quiet_phase = 1'b1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 140) : $urandom_range(0, 20);
			for (int i = 0; i < len; i++)
				send_request(8'($urandom), $urandom_range(0, 7) != 0, 1'b0);
			send_request(8'($urandom), 1'($urandom), 1'b1);
		end

		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
